// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on a given clock, masked while the given reset is low.
`define ASSERT_AT(label, clock, rst_n, prop, msg) \
	label: assert property (@(posedge clock) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check a property on the block clock and reset.
`define ASSERT_CLK(label, prop, msg) \
	`ASSERT_AT(label, clk, arst_n, prop, msg)

`endif

// ===== rtl/core/smc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package smc_pkg;

	localparam int MODE_W  = 3;
	localparam int FUNC_W  = 2;
	localparam int EVENT_W = 4;
	localparam int ERR_W   = 4;
	localparam int CNT_W   = 32;
	localparam int TMO_W   = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// modes
	localparam logic [MODE_W-1:0] M_IDLE   = 3'd0;
	localparam logic [MODE_W-1:0] M_INIT   = 3'd1;
	localparam logic [MODE_W-1:0] M_SCAN   = 3'd2;
	localparam logic [MODE_W-1:0] M_TARGET = 3'd3;
	localparam logic [MODE_W-1:0] M_ALARM  = 3'd4;
	localparam logic [MODE_W-1:0] M_CALIB  = 3'd5;
	localparam logic [MODE_W-1:0] M_ERROR  = 3'd6;

	// item kinds
	localparam logic [FUNC_W-1:0] F_EVENT   = 2'd0;
	localparam logic [FUNC_W-1:0] F_TICK    = 2'd1;
	localparam logic [FUNC_W-1:0] F_SET_ERR = 2'd2;
	localparam logic [FUNC_W-1:0] F_CLR_ERR = 2'd3;

	// events
	localparam logic [EVENT_W-1:0] EV_NONE          = 4'd0;
	localparam logic [EVENT_W-1:0] EV_INIT_DONE     = 4'd1;
	localparam logic [EVENT_W-1:0] EV_TARGET_SEEN   = 4'd3;
	localparam logic [EVENT_W-1:0] EV_TARGET_GONE   = 4'd4;
	localparam logic [EVENT_W-1:0] EV_ALARM_ON      = 4'd5;
	localparam logic [EVENT_W-1:0] EV_ALARM_OFF     = 4'd6;
	localparam logic [EVENT_W-1:0] EV_FAULT         = 4'd7;
	localparam logic [EVENT_W-1:0] EV_FAULT_CLEARED = 4'd8;
	localparam logic [EVENT_W-1:0] EV_CALIB_REQ     = 4'd9;
	localparam logic [EVENT_W-1:0] EV_CALIB_DONE    = 4'd10;
	localparam logic [EVENT_W-1:0] EV_LIMIT         = 4'd12;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_TMO  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CALIB_TMO = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CRIT_ERR  = 2'd2;

	localparam logic [TMO_W-1:0] INIT_TMO_RST  = 16'd5000;
	localparam logic [TMO_W-1:0] CALIB_TMO_RST = 16'd10000;
	localparam logic [ERR_W-1:0] CRIT_ERR_RST  = 4'd1;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [MODE_W-1:0] prior_mode;
		logic              mode_changed;
		logic              target_lock;
		logic [ERR_W-1:0]  error_now;
		logic              in_error;
		logic [CNT_W-1:0]  scans_done;
		logic [CNT_W-1:0]  ms_in_mode;
		logic [CNT_W-1:0]  up_ticks;
	} result_t;

endpackage
`default_nettype wire

// ===== rtl/core/smc_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface smc_in_if import smc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FUNC_W-1:0]  func;
	logic [EVENT_W-1:0] event_code;
	logic [ERR_W-1:0]   error_code;

	modport source (output valid, output func, output event_code, output error_code,
		input ready);
	modport sink (input valid, input func, input event_code, input error_code,
		output ready);
endinterface
`default_nettype wire

// ===== rtl/core/smc_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface smc_out_if import smc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [MODE_W-1:0] prior_mode;
	logic              mode_changed;
	logic              target_lock;
	logic [ERR_W-1:0]  error_now;
	logic              in_error;
	logic [CNT_W-1:0]  scans_done;
	logic [CNT_W-1:0]  ms_in_mode;
	logic [CNT_W-1:0]  up_ticks;

	modport source (output valid, output mode, output prior_mode, output mode_changed,
		output target_lock, output error_now, output in_error, output scans_done,
		output ms_in_mode, output up_ticks, input ready);
	modport sink (input valid, input mode, input prior_mode, input mode_changed,
		input target_lock, input error_now, input in_error, input scans_done,
		input ms_in_mode, input up_ticks, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/sensor_mode_controller.sv =====
// An input transfer's result is loaded into the output register in the cycle after it.
// Throughput: one item per cycle unless the output stalls; the next item is taken in the
//   same cycle the held result is transferred, so the mode state and counters settle in one pass.
// Reset (arst_n low, asynchronous): mode init, prior mode idle, lock, error and all
//   counters zero, timeouts back to 5000 / 10000 ms, critical error code 1.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sensor_mode_controller import smc_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	smc_in_if.sink                     req,
	smc_out_if.source                  rsp
);

	// Transition table: return the current mode when the event has no edge out of it.
	function automatic logic [MODE_W-1:0] next_mode(
		input logic [MODE_W-1:0]  m,
		input logic [EVENT_W-1:0] ev
	);
		logic [MODE_W-1:0] nm;
		nm = m;
		case (m)
			M_IDLE: begin
				if (ev == EV_INIT_DONE) nm = M_SCAN;
				else if (ev == EV_CALIB_REQ) nm = M_CALIB;
				else if (ev == EV_FAULT) nm = M_ERROR;
			end
			M_INIT: begin
				if (ev == EV_INIT_DONE) nm = M_SCAN;
				else if (ev == EV_FAULT) nm = M_ERROR;
			end
			M_SCAN: begin
				if (ev == EV_TARGET_SEEN) nm = M_TARGET;
				else if (ev == EV_CALIB_REQ) nm = M_CALIB;
				else if (ev == EV_FAULT) nm = M_ERROR;
			end
			M_TARGET: begin
				if (ev == EV_TARGET_GONE) nm = M_SCAN;
				else if (ev == EV_ALARM_ON) nm = M_ALARM;
				else if (ev == EV_FAULT) nm = M_ERROR;
			end
			M_ALARM: begin
				if (ev == EV_ALARM_OFF || ev == EV_TARGET_GONE) nm = M_SCAN;
				else if (ev == EV_FAULT) nm = M_ERROR;
			end
			M_CALIB: begin
				if (ev == EV_CALIB_DONE) nm = M_SCAN;
				else if (ev == EV_FAULT) nm = M_ERROR;
			end
			M_ERROR: begin
				if (ev == EV_FAULT_CLEARED) nm = M_INIT;
			end
			default: begin
				// unused mode code: no transitions
				nm = m;
			end
		endcase
		return nm;
	endfunction

	// Configuration registers.
	logic [TMO_W-1:0] init_tmo_q;
	logic [TMO_W-1:0] calib_tmo_q;
	logic [ERR_W-1:0] crit_err_q;

	// Controller state.
	logic [MODE_W-1:0] mode_q;
	logic [MODE_W-1:0] prior_q;
	logic              lock_q;
	logic [ERR_W-1:0]  err_q;
	logic [CNT_W-1:0]  scan_q;
	logic [CNT_W-1:0]  timer_q;
	logic [CNT_W-1:0]  uptime_q;

	// Output register.
	logic    valid_s1;
	result_t res_s1;

	// Next-state values for the item on the input.
	logic [MODE_W-1:0]  mode_d;
	logic [MODE_W-1:0]  prior_d;
	logic               lock_d;
	logic [ERR_W-1:0]   err_d;
	logic [CNT_W-1:0]   scan_d;
	logic [CNT_W-1:0]   timer_d;
	logic [CNT_W-1:0]   uptime_d;
	logic [CNT_W-1:0]   timer_inc;
	logic [EVENT_W-1:0] ev;
	logic               ev_en;
	logic [MODE_W-1:0]  nm;
	logic               changed;
	logic               in_xfer;

	// Take a new item whenever the output register is empty or drains this cycle.
	assign req.ready = !valid_s1 || rsp.ready;
	assign in_xfer   = req.valid && req.ready;

	assign timer_inc = (timer_q == {CNT_W{1'b1}}) ? timer_q : timer_q + {{(CNT_W-1){1'b0}}, 1'b1};

	always_comb begin
		ev       = EV_NONE;
		ev_en    = 1'b0;
		err_d    = err_q;
		scan_d   = scan_q;
		timer_d  = timer_q;
		uptime_d = uptime_q;
		case (req.func)
			F_EVENT: begin
				// codes at or above the limit are dropped
				ev    = req.event_code;
				ev_en = (req.event_code < EV_LIMIT);
			end
			F_TICK: begin
				uptime_d = uptime_q + {{(CNT_W-1){1'b0}}, 1'b1};
				timer_d  = timer_inc;
				if (mode_q == M_SCAN) begin
					scan_d = scan_q + {{(CNT_W-1){1'b0}}, 1'b1};
				end else if (mode_q == M_INIT) begin
					// init timeout: record the critical code and force error
					if (timer_inc > {{(CNT_W-TMO_W){1'b0}}, init_tmo_q}) begin
						err_d = crit_err_q;
						ev    = EV_FAULT;
						ev_en = 1'b1;
					end
				end else if (mode_q == M_CALIB) begin
					// calibration timeout: complete on its own
					if (timer_inc > {{(CNT_W-TMO_W){1'b0}}, calib_tmo_q}) begin
						ev    = EV_CALIB_DONE;
						ev_en = 1'b1;
					end
				end
			end
			F_SET_ERR: begin
				err_d = req.error_code;
			end
			F_CLR_ERR: begin
				// clear in every mode; only error leaves
				err_d = '0;
				ev    = EV_FAULT_CLEARED;
				ev_en = 1'b1;
			end
			default: begin
				ev_en = 1'b0;
			end
		endcase

		nm      = next_mode(mode_q, ev);
		changed = ev_en && (nm != mode_q);

		mode_d  = mode_q;
		prior_d = prior_q;
		lock_d  = lock_q;
		if (changed) begin
			// record the mode we leave, restart the mode timer, update lock
			prior_d = mode_q;
			mode_d  = nm;
			timer_d = '0;
			if (nm == M_SCAN) lock_d = 1'b0;
			if (nm == M_TARGET) lock_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_tmo_q  <= INIT_TMO_RST;
			calib_tmo_q <= CALIB_TMO_RST;
			crit_err_q  <= CRIT_ERR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_INIT_TMO:  init_tmo_q  <= cfg_data[TMO_W-1:0];
				CFG_CALIB_TMO: calib_tmo_q <= cfg_data[TMO_W-1:0];
				CFG_CRIT_ERR:  crit_err_q  <= cfg_data[ERR_W-1:0];
				default: begin
					// writes beyond the register list are dropped
					crit_err_q <= crit_err_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_INIT;
			prior_q  <= M_IDLE;
			lock_q   <= 1'b0;
			err_q    <= '0;
			scan_q   <= '0;
			timer_q  <= '0;
			uptime_q <= '0;
		end else if (in_xfer) begin
			mode_q   <= mode_d;
			prior_q  <= prior_d;
			lock_q   <= lock_d;
			err_q    <= err_d;
			scan_q   <= scan_d;
			timer_q  <= timer_d;
			uptime_q <= uptime_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s1 <= 1'b0;
		end
	end

	// Result payload: load on every input transfer, hold otherwise.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			res_s1.mode         <= mode_d;
			res_s1.prior_mode   <= prior_d;
			res_s1.mode_changed <= changed;
			res_s1.target_lock  <= lock_d;
			res_s1.error_now    <= err_d;
			res_s1.in_error     <= (mode_d == M_ERROR);
			res_s1.scans_done   <= scan_d;
			res_s1.ms_in_mode   <= timer_d;
			res_s1.up_ticks     <= uptime_d;
		end
	end

	assign rsp.valid        = valid_s1;
	assign rsp.mode         = res_s1.mode;
	assign rsp.prior_mode   = res_s1.prior_mode;
	assign rsp.mode_changed = res_s1.mode_changed;
	assign rsp.target_lock  = res_s1.target_lock;
	assign rsp.error_now    = res_s1.error_now;
	assign rsp.in_error     = res_s1.in_error;
	assign rsp.scans_done   = res_s1.scans_done;
	assign rsp.ms_in_mode   = res_s1.ms_in_mode;
	assign rsp.up_ticks     = res_s1.up_ticks;

	`ASSERT_CLK(a_change_moves, rsp.valid && rsp.mode_changed |-> rsp.mode != rsp.prior_mode, "mode change without a new mode")
	`ASSERT_CLK(a_change_clears_timer, rsp.valid && rsp.mode_changed |-> rsp.ms_in_mode == '0, "mode timer not restarted on change")
	`ASSERT_CLK(a_in_error_match, rsp.valid |-> rsp.in_error == (rsp.mode == M_ERROR), "in_error disagrees with mode")
	`ASSERT_CLK(a_tick_uptime, in_xfer && req.func == F_TICK |=> uptime_q == $past(uptime_q) + 32'd1, "tick did not advance uptime")
	`ASSERT_CLK(a_no_tick_uptime, in_xfer && req.func != F_TICK |=> $stable(uptime_q), "uptime moved without a tick")

endmodule
`default_nettype wire
